### design/tsam_pkg.sv
// Shared types and constants for the touch sample averaging and mapping block.
// Holds register codes, reset values, state and operation codes, and link structs.
// No dependencies.
package tsam_pkg;

  // Field and datapath widths.
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned OFS_W     = 16;
  localparam int unsigned CPP_W     = 40;
  localparam int unsigned CFG_W     = 40;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned DVD_W     = 24;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET = 2'd0,
    REG_Y_OFFSET = 2'd1,
    REG_X_CPP    = 2'd2,
    REG_Y_CPP    = 2'd3
  } tsam_reg_e;

  // Register values after reset.
  localparam logic [OFS_W-1:0] X_OFFSET_RST = 16'd4270;
  localparam logic [OFS_W-1:0] Y_OFFSET_RST = 16'd3855;
  localparam logic [CPP_W-1:0] X_CPP_RST    = 40'd4407040;
  localparam logic [CPP_W-1:0] Y_CPP_RST    = 40'd18100522752;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOISY = 1'b1;

  // Top level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOISY,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } tsam_state_e;

  // Divisions run for one finished window, in this order.
  typedef enum logic [1:0] {
    OP_AVG_X,
    OP_AVG_Y,
    OP_MAP_X,
    OP_MAP_Y
  } tsam_op_e;

  // Accumulator control.
  typedef struct packed {
    logic add;
    logic clear;
  } tsam_acc_ctrl_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } tsam_div_sts_t;

endpackage

### design/tsam_accum.sv
// Running X and Y sums and the window sample counter.
// Depends on tsam_pkg.
module tsam_accum #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsam_pkg::tsam_acc_ctrl_t     ctrl_i,
  input  logic [tsam_pkg::RAW_W-1:0]   raw_x_i,
  input  logic [tsam_pkg::RAW_W-1:0]   raw_y_i,
  output logic [tsam_pkg::SUM_W-1:0]   sum_x_o,
  output logic [tsam_pkg::SUM_W-1:0]   sum_y_o,
  output logic                         last_o
);
  import tsam_pkg::*;

  localparam int unsigned CntW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES - 1);

  logic [SUM_W-1:0] sum_x_q, sum_x_d;
  logic [SUM_W-1:0] sum_y_q, sum_y_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // The next added beat completes the window.
  assign last_o = (cnt_q == LastCnt);

  // Sums wrap at their width; clear wins over add.
  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (ctrl_i.clear) begin
      sum_x_d = '0;
      sum_y_d = '0;
      cnt_d   = '0;
    end else if (ctrl_i.add) begin
      sum_x_d = sum_x_q + SUM_W'(raw_x_i);
      sum_y_d = sum_y_q + SUM_W'(raw_y_i);
      cnt_d   = last_o ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;

endmodule

### design/tsam_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tsam_pkg.
module tsam_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsam_pkg::DVD_W-1:0]   dividend_i,
  input  logic [tsam_pkg::CPP_W-1:0]   divisor_i,
  output tsam_pkg::tsam_div_sts_t      sts_o,
  output logic [tsam_pkg::DVD_W-1:0]   quotient_o
);
  import tsam_pkg::*;

  localparam int unsigned CntW = $clog2(DVD_W);
  localparam logic [CntW-1:0] LastStep = CntW'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CPP_W-1:0] rem_q, rem_d;
  logic [CPP_W-1:0] div_q, div_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [CPP_W:0]   trial;
  logic [CPP_W:0]   trial_sub;
  logic             fits;

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial     = {rem_q, quo_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign fits      = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[CPP_W-1:0] : trial[CPP_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

### design/touch_sample_average_map.sv
// Touch sample averaging and linear screen mapping, top level.
// Depends on tsam_pkg, tsam_accum and tsam_divider.
//
// Input channel (in_valid_i/in_ready_o) carries one raw X/Y sample beat with a
// pen-down flag. Output channel (out_valid_o/out_ready_i) carries one result beat:
// screen X/Y, averaged raw X/Y and a status bit. Registers are written through
// cfg_we_i/cfg_index_i/cfg_data_i; the user writes them only while the block is
// idle, which the block itself does not enforce. A pen-down beat that does not
// close the window is absorbed without leaving the idle state and gives no result.
// The beat that closes a window of SAMPLES beats starts four divisions on one
// shared bit-serial divider (two averages, two mappings), run one after another;
// a mapping whose difference is not positive skips its division.
// A pen-up beat clears the window; the noisy state then loads a NOISY result.
// Input is taken only in the idle state, never while divisions run or a result waits.
// The result sits in an output register; if the receiver stalls, the block
// still takes further pen-down beats that give no result, and otherwise holds
// its finished result until the output register frees.
// Reset clears the sums, the count and the sequencer, and loads the register
// defaults; no result is pending after reset.
module touch_sample_average_map #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [tsam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsam_pkg::CFG_W-1:0]     cfg_data_i,
  // Sample input.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tsam_pkg::RAW_W-1:0]     raw_x_i,
  input  logic [tsam_pkg::RAW_W-1:0]     raw_y_i,
  input  logic                           pen_down_i,
  // Result output.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tsam_pkg::RAW_W-1:0]     screen_x_o,
  output logic [tsam_pkg::RAW_W-1:0]     screen_y_o,
  output logic [tsam_pkg::RAW_W-1:0]     avg_raw_x_o,
  output logic [tsam_pkg::RAW_W-1:0]     avg_raw_y_o,
  output logic                           status_o
);
  import tsam_pkg::*;

  localparam logic [CPP_W-1:0] SamplesDiv = CPP_W'(SAMPLES);

  tsam_state_e state_q, state_d;
  tsam_op_e    op_q, op_d;

  logic [OFS_W-1:0] x_offset_q, y_offset_q;
  logic [CPP_W-1:0] x_cpp_q, y_cpp_q;

  tsam_acc_ctrl_t   acc_ctrl;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic             acc_last;

  logic             div_start;
  tsam_div_sts_t    div_sts;
  logic [DVD_W-1:0] div_dividend;
  logic [CPP_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quo;

  logic [RAW_W-1:0] ax_q, ay_q, sx_q, sy_q;
  logic [RAW_W-1:0] res_val;
  logic             res_we;
  logic             op_adv;
  logic             skip;
  logic             is_map;
  logic [RAW_W-1:0] sat_quo;
  logic             in_acc;
  logic             out_free;
  logic             load_ok;
  logic             load_noisy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q <= X_OFFSET_RST;
      y_offset_q <= Y_OFFSET_RST;
      x_cpp_q    <= X_CPP_RST;
      y_cpp_q    <= Y_CPP_RST;
    end else if (cfg_we_i) begin
      case (tsam_reg_e'(cfg_index_i))
        REG_X_OFFSET: x_offset_q <= cfg_data_i[OFS_W-1:0];
        REG_Y_OFFSET: y_offset_q <= cfg_data_i[OFS_W-1:0];
        REG_X_CPP:    x_cpp_q    <= cfg_data_i[CPP_W-1:0];
        REG_Y_CPP:    y_cpp_q    <= cfg_data_i[CPP_W-1:0];
        default: ;
      endcase
    end
  end

  tsam_accum #(
    .SAMPLES (SAMPLES)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .raw_x_i (raw_x_i),
    .raw_y_i (raw_y_i),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y),
    .last_o  (acc_last)
  );

  tsam_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  // Divider operands and skip test for the current operation.
  always_comb begin
    div_dividend = '0;
    div_divisor  = SamplesDiv;
    skip         = 1'b0;
    is_map       = 1'b0;
    case (op_q)
      OP_AVG_X: div_dividend = sum_x;
      OP_AVG_Y: div_dividend = sum_y;
      OP_MAP_X: begin
        is_map       = 1'b1;
        skip         = (ax_q <= x_offset_q);
        div_dividend = {ax_q - x_offset_q, FRAC_W'(0)};
        div_divisor  = x_cpp_q;
      end
      OP_MAP_Y: begin
        is_map       = 1'b1;
        skip         = (ay_q <= y_offset_q);
        div_dividend = {ay_q - y_offset_q, FRAC_W'(0)};
        div_divisor  = y_cpp_q;
      end
      default: ;
    endcase
  end

  // Mapping quotients above the result range saturate.
  assign sat_quo  = (|div_quo[DVD_W-1:RAW_W]) ? '1 : div_quo[RAW_W-1:0];
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!pen_down_i) begin
            state_d = ST_NOISY;
          end else if (acc_last) begin
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_NOISY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_GO: begin
        if (is_map && skip) begin
          state_d = (op_q == OP_MAP_Y) ? ST_EMIT : ST_DIV_GO;
        end else begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          state_d = (op_q == OP_MAP_Y) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    acc_ctrl.add   = 1'b0;
    acc_ctrl.clear = 1'b0;
    div_start      = 1'b0;
    res_we         = 1'b0;
    res_val        = '0;
    op_adv         = 1'b0;
    load_ok        = 1'b0;
    load_noisy     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        acc_ctrl.add   = in_acc && pen_down_i;
        acc_ctrl.clear = in_acc && !pen_down_i;
      end
      ST_NOISY: begin
        load_noisy = out_free;
      end
      ST_DIV_GO: begin
        if (is_map && skip) begin
          res_we = 1'b1;
          op_adv = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          res_we  = 1'b1;
          res_val = is_map ? sat_quo : div_quo[RAW_W-1:0];
          op_adv  = 1'b1;
        end
      end
      ST_EMIT: begin
        acc_ctrl.clear = 1'b1;
        load_ok        = out_free;
      end
      default: ;
    endcase
  end

  // State and operation registers.
  assign op_d = (state_q == ST_IDLE) ? OP_AVG_X :
                op_adv ? tsam_op_e'(op_q + 2'd1) : op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_AVG_X;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Per-window results.
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      case (op_q)
        OP_AVG_X: ax_q <= res_val;
        OP_AVG_Y: ay_q <= res_val;
        OP_MAP_X: sx_q <= res_val;
        OP_MAP_Y: sy_q <= res_val;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_ok || load_noisy) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      screen_x_o  <= sx_q;
      screen_y_o  <= sy_q;
      avg_raw_x_o <= ax_q;
      avg_raw_y_o <= ay_q;
      status_o    <= STATUS_OK;
    end else if (load_noisy) begin
      screen_x_o  <= '0;
      screen_y_o  <= '0;
      avg_raw_x_o <= '0;
      avg_raw_y_o <= '0;
      status_o    <= STATUS_NOISY;
    end
  end

  // A noisy result never carries coordinates.
  a_noisy_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_NOISY |->
      screen_x_o == '0 && screen_y_o == '0 && avg_raw_x_o == '0 && avg_raw_y_o == '0)
    else $error("noisy result with nonzero coordinates");

  // The divider is never restarted while it works.
  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // The emit state is entered only right after the last mapping.
  a_emit_after_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && $past(state_q) != ST_EMIT |-> $past(op_q) == OP_MAP_Y)
    else $error("emit reached before the Y mapping");

  // A pen-up beat always leads to the noisy result state.
  a_penup_noisy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !pen_down_i |=> state_q == ST_NOISY)
    else $error("pen-up beat did not abort the window");

endmodule

### tb/touch_sample_average_map_test.sv
// Self-checking testbench for touch_sample_average_map: drives sample beats, predicts
// averaged and mapped results from its own window model, and checks every result beat.
// Depends on tsam_pkg and the touch_sample_average_map RTL.
module touch_sample_average_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsam_pkg::*;

  localparam int unsigned WINDOW      = 16;
  localparam int          SETTLE      = 8;
  localparam int          END_SETTLE  = 150;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PRINT_LIMIT = 40;

  typedef struct packed {
    logic [RAW_W-1:0] screen_x;
    logic [RAW_W-1:0] screen_y;
    logic [RAW_W-1:0] avg_x;
    logic [RAW_W-1:0] avg_y;
    logic             status;
  } touch_result_t;

  // Block inputs, all known from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [RAW_W-1:0]     raw_x_i     = '0;
  logic [RAW_W-1:0]     raw_y_i     = '0;
  logic                 pen_down_i  = 1'b0;
  logic                 out_ready_i = 1'b0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [RAW_W-1:0] screen_x_o;
  logic [RAW_W-1:0] screen_y_o;
  logic [RAW_W-1:0] avg_raw_x_o;
  logic [RAW_W-1:0] avg_raw_y_o;
  logic             status_o;

  // Calibration and window state mirrored by the testbench.
  logic [OFS_W-1:0] cal_x_offset = X_OFFSET_RST;
  logic [OFS_W-1:0] cal_y_offset = Y_OFFSET_RST;
  logic [CPP_W-1:0] cal_x_cpp    = X_CPP_RST;
  logic [CPP_W-1:0] cal_y_cpp    = Y_CPP_RST;
  logic [SUM_W-1:0] win_sum_x    = '0;
  logic [SUM_W-1:0] win_sum_y    = '0;
  logic [8:0]       win_count    = '0;

  touch_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int cfg_round     = 0;

  touch_sample_average_map #(
    .SAMPLES(WINDOW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_x_i    (raw_x_i),
    .raw_y_i    (raw_y_i),
    .pen_down_i (pen_down_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .screen_x_o (screen_x_o),
    .screen_y_o (screen_y_o),
    .avg_raw_x_o(avg_raw_x_o),
    .avg_raw_y_o(avg_raw_y_o),
    .status_o   (status_o)
  );

  // Free-running clock with a 2 ns period.
  always #1 clk_i = ~clk_i;

  // The cycle counter ends a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Maps one averaged axis to a screen coordinate with saturation at both ends.
  function automatic logic [RAW_W-1:0] scale_to_screen(input logic [RAW_W-1:0] avg,
                                                       input logic [OFS_W-1:0] offset,
                                                       input logic [CPP_W-1:0] cpp);
    logic [63:0] scaled;
    logic [63:0] quot;
    if (avg <= offset) return '0;
    if (cpp == '0) return 16'hFFFF;
    scaled = {48'd0, 16'(avg - offset)} << FRAC_W;
    quot   = scaled / {24'd0, cpp};
    return (quot > 64'hFFFF) ? 16'hFFFF : quot[RAW_W-1:0];
  endfunction

  // Updates the window with one accepted beat and queues the result it causes.
  task automatic absorb_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                               input logic pen);
    touch_result_t res;
    logic [RAW_W-1:0] ax;
    logic [RAW_W-1:0] ay;
    res = '0;
    if (!pen) begin
      win_sum_x  = '0;
      win_sum_y  = '0;
      win_count  = '0;
      res.status = STATUS_NOISY;
      pending_results.push_back(res);
    end else begin
      win_sum_x = win_sum_x + SUM_W'(x);
      win_sum_y = win_sum_y + SUM_W'(y);
      win_count = win_count + 9'd1;
      if (win_count >= WINDOW) begin
        ax           = RAW_W'(win_sum_x / WINDOW);
        ay           = RAW_W'(win_sum_y / WINDOW);
        res.screen_x = scale_to_screen(ax, cal_x_offset, cal_x_cpp);
        res.screen_y = scale_to_screen(ay, cal_y_offset, cal_y_cpp);
        res.avg_x    = ax;
        res.avg_y    = ay;
        res.status   = STATUS_OK;
        pending_results.push_back(res);
        win_sum_x = '0;
        win_sum_y = '0;
        win_count = '0;
      end
    end
  endtask

  // Sends one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                             input logic pen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_x_i    <= x;
    raw_y_i    <= y;
    pen_down_i <= pen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_sample(x, y, pen);
    samples_sent++;
  endtask

  // Drops valid, waits for every queued result, then lets the block settle.
  task automatic drain_and_settle(input int settle_cycles);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it; the caller lowers the write enable.
  task automatic write_reg(input tsam_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_X_OFFSET: cal_x_offset = data[OFS_W-1:0];
      REG_Y_OFFSET: cal_y_offset = data[OFS_W-1:0];
      REG_X_CPP:    cal_x_cpp    = data[CPP_W-1:0];
      REG_Y_CPP:    cal_y_cpp    = data[CPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] x_ofs, input logic [CFG_W-1:0] y_ofs,
                              input logic [CFG_W-1:0] x_cpp, input logic [CFG_W-1:0] y_cpp);
    write_reg(REG_X_OFFSET, x_ofs);
    write_reg(REG_Y_OFFSET, y_ofs);
    write_reg(REG_X_CPP, x_cpp);
    write_reg(REG_Y_CPP, y_cpp);
    cfg_we_i <= 1'b0;
  endtask

  // Random divisor drawn from several magnitude bands.
  function automatic logic [CFG_W-1:0] random_cpp();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return CFG_W'($urandom_range(1, 1 << 20));
      1:       return wide[CFG_W-1:0];
      2:       return CFG_W'(256 * $urandom_range(1, 64));
      default: return CFG_W'($urandom_range(1, 300));
    endcase
  endfunction

  // Offset word with junk in the unused upper bits.
  function automatic logic [CFG_W-1:0] offset_word(input logic [OFS_W-1:0] ofs);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return {wide[CFG_W-1:OFS_W], ofs};
  endfunction

  // The first settings walk through the extremes and the reset calibration, later ones are random.
  task automatic pick_config();
    case (cfg_round)
      0: apply_config(offset_word(16'd0), offset_word(16'd0), 40'd1, 40'd1);
      1: apply_config(offset_word(16'hFFFF), offset_word(16'hFFFF), {CFG_W{1'b1}},
                      {CFG_W{1'b1}});
      2: apply_config(offset_word(16'd0), offset_word(16'd0), 40'd0, 40'd0);
      3: apply_config(offset_word(16'd0), offset_word(16'hFFFF), {CFG_W{1'b1}}, 40'd0);
      4: apply_config(40'(X_OFFSET_RST), 40'(Y_OFFSET_RST), X_CPP_RST, Y_CPP_RST);
      5: apply_config(offset_word(16'($urandom)), offset_word(16'($urandom)), 40'd256,
                      40'd256);
      default: apply_config(offset_word(16'($urandom)), offset_word(16'($urandom)),
                            random_cpp(), random_cpp());
    endcase
    cfg_round++;
  endtask

  // A sample that differs from the window's base value only in the masked bits.
  function automatic logic [RAW_W-1:0] jitter(input logic [RAW_W-1:0] base,
                                              input logic [RAW_W-1:0] mask);
    return base ^ (RAW_W'($urandom) & mask);
  endfunction

  // One random sequence: mostly whole windows, some aborted ones and some noise.
  task automatic send_sequence();
    logic [RAW_W-1:0] base_x;
    logic [RAW_W-1:0] base_y;
    logic [RAW_W-1:0] mask;
    int k;
    base_x = RAW_W'($urandom);
    base_y = RAW_W'($urandom);
    mask   = 16'hFFFF >> $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0: send_sample(RAW_W'($urandom), RAW_W'($urandom), 1'b0);
      1: begin
        k = $urandom_range(1, WINDOW - 1);
        repeat (k) send_sample(jitter(base_x, mask), jitter(base_y, mask), 1'b1);
        send_sample(RAW_W'($urandom), RAW_W'($urandom), 1'b0);
      end
      2: begin
        k = $urandom_range(1, 6);
        repeat (k) send_sample(RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
      end
      default: begin
        do send_sample(jitter(base_x, mask), jitter(base_y, mask), 1'b1);
        while (win_count != 0);
      end
    endcase
  endtask

  // Pen-up with an empty window, then a window aborted after a few samples.
  task automatic test_pen_up_cases();
    send_sample(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'd1, 16'd2, 1'b1);
    send_sample(16'd3, 16'd4, 1'b1);
    send_sample(16'd5, 16'd6, 1'b1);
    send_sample(16'd0, 16'd0, 1'b0);
    drain_and_settle(SETTLE);
  endtask

  // One full window at the raw extremes under the reset calibration.
  task automatic test_default_window();
    repeat (WINDOW) send_sample(16'hFFFF, 16'd0, 1'b1);
    drain_and_settle(SETTLE);
  endtask

  // Random traffic in three calibration segments with the given idle rates.
  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_items);
    int seg_start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (3) begin
      drain_and_settle(SETTLE);
      pick_config();
      seg_start = samples_sent;
      while (samples_sent - seg_start < n_items / 3) send_sequence();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [RAW_W-1:0] got,
                                 input logic [RAW_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
  endtask

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Each result beat is checked against the oldest queued prediction.
  always @(posedge clk_i) begin : check_results
    touch_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result screen_x", screen_x_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (screen_x_o !== want.screen_x) report_mismatch("screen_x", screen_x_o, want.screen_x);
        if (screen_y_o !== want.screen_y) report_mismatch("screen_y", screen_y_o, want.screen_y);
        if (avg_raw_x_o !== want.avg_x) report_mismatch("avg_raw_x", avg_raw_x_o, want.avg_x);
        if (avg_raw_y_o !== want.avg_y) report_mismatch("avg_raw_y", avg_raw_y_o, want.avg_y);
        if (status_o !== want.status)
          report_mismatch("status", RAW_W'(status_o), RAW_W'(want.status));
      end
      results_seen++;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pen_up_cases();
    test_default_window();
    test_random_traffic(14, 73, 135);
    test_random_traffic(73, 14, 135);
    test_random_traffic(0, 0, 135);
    drain_and_settle(END_SETTLE);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/tsam_pkg.sv
design/tsam_accum.sv
design/tsam_divider.sv
design/touch_sample_average_map.sv
tb/touch_sample_average_map_test.sv
